@@ rtl/core/gqtl_pkg.sv @@
// gqtl_pkg: types and constants shared by the glyph quad text layout block
// used by gqtl_glyph_mem, gqtl_atlas_div and glyph_quad_text_layout
`timescale 1ns / 1ps

package gqtl_pkg;

    localparam int NUM_GLYPHS_DEF = 256;

    localparam int CODE_W   = 8;
    localparam int POS_W    = 32;
    localparam int COORD_W  = 17;
    localparam int COUNT_W  = 16;
    localparam int CFG_W    = 16;
    localparam int OFFS_W   = 12;
    localparam int FRAC_W   = 6;

    // restoring division steps: one overflow bit plus 17 coordinate bits
    localparam int DIV_STEPS = 18;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int REM_W     = 29;

    localparam logic [COORD_W-1:0] COORD_MAX = 17'd65536;
    localparam logic [CODE_W-1:0]  NEWLINE_CODE = 8'd10;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_CHAR = 2'd1,
        MODE_END  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        CFG_CELL_WIDTH  = 2'd0,
        CFG_CELL_HEIGHT = 2'd1,
        CFG_HIGHEST_TOP = 2'd2,
        CFG_QUAD_LIMIT  = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DIVIDE,
        ST_EMIT,
        ST_REPORT
    } t_state;

    typedef struct packed {
        logic [7:0]         w;
        logic [7:0]         h;
        logic signed [7:0]  left;
        logic signed [7:0]  top;
        logic signed [15:0] adv_x;
        logic signed [15:0] adv_y;
    } t_glyph;

    typedef struct packed {
        logic              start;
        logic [OFFS_W-1:0] offset;
        logic [7:0]        cell_size;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [COORD_W-1:0] coord;
    } t_div_rsp;

endpackage

@@ rtl/core/gqtl_glyph_mem.sv @@
// gqtl_glyph_mem: glyph metrics memory with per-entry valid bits
// unwritten entries read as zero; depends on gqtl_pkg
`timescale 1ns / 1ps

module gqtl_glyph_mem #(
    parameter int NUM_GLYPHS = gqtl_pkg::NUM_GLYPHS_DEF,
    parameter int IDX_W      = $clog2(NUM_GLYPHS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  gqtl_pkg::t_glyph i_wr_data,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output gqtl_pkg::t_glyph o_rd_data
);
    import gqtl_pkg::*;

    t_glyph                r_mem [NUM_GLYPHS];
    logic [NUM_GLYPHS-1:0] r_valid;
    t_glyph                r_rd_data;
    logic                  r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

@@ rtl/core/gqtl_atlas_div.sv @@
// gqtl_atlas_div: serial restoring divider for atlas coordinates
// round(offset * 65536 / (16 * cell)) limited to 1.0; depends on gqtl_pkg
`timescale 1ns / 1ps

module gqtl_atlas_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gqtl_pkg::t_div_req i_req,
    output gqtl_pkg::t_div_rsp o_rsp
);
    import gqtl_pkg::*;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    logic               r_busy;
    logic [STEP_W-1:0]  r_step;
    logic               r_done;
    logic [REM_W-1:0]   r_rem;
    logic [REM_W-1:0]   r_dvs;
    logic [DIV_STEPS-1:0] r_quo;
    logic [COORD_W-1:0] r_coord;

    logic [REM_W-1:0]     num;
    logic [REM_W:0]       diff;
    logic                 take;
    logic [DIV_STEPS-1:0] quo_next;
    logic                 load;

    // dividend carries the half-divisor rounding term
    assign num      = {1'b0, i_req.offset, 16'd0} + REM_W'({i_req.cell_size, 3'd0});
    assign diff     = {1'b0, r_rem} - {1'b0, r_dvs};
    assign take     = !diff[REM_W];
    assign quo_next = {r_quo[DIV_STEPS-2:0], take};
    assign load     = i_req.start && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (load) begin
                r_step <= '0;
                if (i_req.cell_size == 8'd0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rem   <= num;
            r_dvs   <= {i_req.cell_size, 21'd0};
            r_quo   <= '0;
            r_coord <= '0;
        end else if (r_busy) begin
            if (take) begin
                r_rem <= diff[REM_W-1:0];
            end
            r_dvs <= r_dvs >> 1;
            r_quo <= quo_next;
            if (r_step == STEP_LAST) begin
                r_coord <= (quo_next > DIV_STEPS'(COORD_MAX)) ? COORD_MAX
                                                              : quo_next[COORD_W-1:0];
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.coord = r_coord;

endmodule

@@ rtl/core/glyph_quad_text_layout.sv @@
// glyph_quad_text_layout: lays out text as screen quads over a 16x16 glyph atlas.
// Input beats carry a mode: load writes one glyph metrics entry, char moves the
// pen and may yield one quad beat, end yields one bounding box beat and clears
// the pen. Output beats carry kind, quad count, 26.6 edges and 1.16 atlas edges.
// Both channels use valid and stall; a beat moves when valid is high and stall low.
// A load beat, a mode 3 beat and a char ignored at the quad limit keep the block idle;
// an end beat passes through report, a newline or an invisible char through lookup.
// A visible char passes through lookup, four atlas coordinates one after another
// through a single 18-step serial divider, and the quad beat.
// An end or visible char takes longer while a stalled result holds the output register.
// Input stall is high while an item is in work; the next input beat is taken while
// a result still sits in the output register. When the receiver stalls, a finished
// result waits in its own state until the output register frees up.
// Configuration is a plain write port with no read-back, to be used while idle.
// Synchronous active-low reset empties the glyph table (valid bits), zeroes the pen
// and quad count, and loads cell size 1 and quad limit 65535.
// Depends on gqtl_pkg, gqtl_glyph_mem and gqtl_atlas_div.
`timescale 1ns / 1ps

module glyph_quad_text_layout #(
    parameter int NUM_GLYPHS = gqtl_pkg::NUM_GLYPHS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    input  logic                                 i_cfg_we,
    input  logic [1:0]                           i_cfg_index,
    input  logic [gqtl_pkg::CFG_W-1:0]           i_cfg_data,

    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [1:0]                           i_mode,
    input  logic [7:0]                           i_char_code,
    input  logic [7:0]                           i_glyph_width,
    input  logic [7:0]                           i_glyph_height,
    input  logic signed [7:0]                    i_glyph_left,
    input  logic signed [7:0]                    i_glyph_top,
    input  logic signed [15:0]                   i_advance_x,
    input  logic signed [15:0]                   i_advance_y,

    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_kind,
    output logic [15:0]                          o_quads_so_far,
    output logic signed [31:0]                   o_x_left,
    output logic signed [31:0]                   o_y_upper,
    output logic signed [31:0]                   o_x_right,
    output logic signed [31:0]                   o_y_lower,
    output logic [16:0]                          o_u_left,
    output logic [16:0]                          o_v_upper,
    output logic [16:0]                          o_u_right,
    output logic [16:0]                          o_v_lower,
    output logic signed [31:0]                   o_box_width,
    output logic signed [31:0]                   o_box_height
);
    import gqtl_pkg::*;

    localparam int IDX_W = $clog2(NUM_GLYPHS);

    t_state r_state, n_state;

    logic [7:0]         r_cell_width;
    logic [7:0]         r_cell_height;
    logic [COUNT_W-1:0] r_quad_limit;
    logic [COUNT_W-1:0] r_quad_count;
    logic [POS_W-1:0]   r_pen_x;
    logic [POS_W-1:0]   r_pen_y;
    logic [POS_W-1:0]   r_widest;
    logic               r_div_started;
    logic [1:0]         r_uv_idx;

    logic [CODE_W-1:0]  r_code;
    t_glyph             r_glyph;
    logic [POS_W-1:0]   r_xl;
    logic [POS_W-1:0]   r_yu;
    logic [OFFS_W-1:0]  r_mx;
    logic [OFFS_W-1:0]  r_my;
    logic [COORD_W-1:0] r_uv [4];

    logic               r_out_valid;
    logic               r_out_kind;
    logic [COUNT_W-1:0] r_out_count;
    logic [POS_W-1:0]   r_out_xl;
    logic [POS_W-1:0]   r_out_yu;
    logic [POS_W-1:0]   r_out_xr;
    logic [POS_W-1:0]   r_out_yl;
    logic [COORD_W-1:0] r_out_ul;
    logic [COORD_W-1:0] r_out_vu;
    logic [COORD_W-1:0] r_out_ur;
    logic [COORD_W-1:0] r_out_vl;
    logic [POS_W-1:0]   r_out_bw;
    logic [POS_W-1:0]   r_out_bh;

    logic     accept;
    logic     limit_hit;
    logic     out_free;
    logic     mem_we;
    logic     mem_re;
    logic     div_start;
    logic     load_quad;
    logic     load_box;
    logic     in_range;
    logic     visible;
    t_glyph   wr_glyph;
    t_glyph   rd_glyph;
    t_glyph   glyph;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [OFFS_W-1:0] div_base;
    logic [OFFS_W-1:0] div_size;
    logic [POS_W-1:0]  adv_x_ext;
    logic [POS_W-1:0]  adv_y_ext;
    logic [POS_W-1:0]  line_pitch;
    logic [POS_W-1:0]  widest_now;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign limit_hit  = (r_quad_count >= r_quad_limit);
    assign out_free   = !r_out_valid || !i_out_stall;

    assign in_range = ({1'b0, r_code} < 9'(NUM_GLYPHS));
    assign glyph    = in_range ? rd_glyph : '0;
    assign visible  = (glyph.w != 8'd0) && (glyph.h != 8'd0);

    assign adv_x_ext  = {{16{r_glyph.adv_x[15]}}, r_glyph.adv_x};
    assign adv_y_ext  = {{16{r_glyph.adv_y[15]}}, r_glyph.adv_y};
    assign line_pitch = {18'd0, r_cell_height, 6'd0};
    assign widest_now = ($signed(r_pen_x) > $signed(r_widest)) ? r_pen_x : r_widest;

    assign wr_glyph.w     = i_glyph_width;
    assign wr_glyph.h     = i_glyph_height;
    assign wr_glyph.left  = i_glyph_left;
    assign wr_glyph.top   = i_glyph_top;
    assign wr_glyph.adv_x = i_advance_x;
    assign wr_glyph.adv_y = i_advance_y;

    gqtl_glyph_mem #(
        .NUM_GLYPHS (NUM_GLYPHS),
        .IDX_W      (IDX_W)
    ) u_glyph_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (mem_we),
        .i_wr_addr (i_char_code[IDX_W-1:0]),
        .i_wr_data (wr_glyph),
        .i_rd_en   (mem_re),
        .i_rd_addr (i_char_code[IDX_W-1:0]),
        .o_rd_data (rd_glyph)
    );

    // u/v selected by index bit 0, near/far edge by bit 1
    assign div_base = r_uv_idx[0] ? r_my : r_mx;
    assign div_size = r_uv_idx[1] ? (r_uv_idx[0] ? OFFS_W'(r_glyph.h) : OFFS_W'(r_glyph.w))
                                  : '0;

    assign div_req.start     = div_start;
    assign div_req.offset    = div_base + div_size;
    assign div_req.cell_size = r_uv_idx[0] ? r_cell_height : r_cell_width;

    gqtl_atlas_div u_atlas_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_mode == MODE_CHAR && !limit_hit) begin
                        n_state = ST_LOOKUP;
                    end else if (i_mode == MODE_END) begin
                        n_state = ST_REPORT;
                    end
                end
            end
            ST_LOOKUP: begin
                if (r_code == NEWLINE_CODE || !visible) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_rsp.done && r_uv_idx == 2'd3) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_REPORT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        div_start = 1'b0;
        load_quad = 1'b0;
        load_box  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                mem_we = accept && (i_mode == MODE_LOAD)
                         && ({1'b0, i_char_code} < 9'(NUM_GLYPHS));
                mem_re = accept && (i_mode == MODE_CHAR);
            end
            ST_DIVIDE: div_start = !r_div_started;
            ST_EMIT:   load_quad = out_free;
            ST_REPORT: load_box  = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_cell_width  <= 8'd1;
            r_cell_height <= 8'd1;
            r_quad_limit  <= 16'hFFFF;
            r_quad_count  <= '0;
            r_pen_x       <= '0;
            r_pen_y       <= '0;
            r_widest      <= '0;
            r_div_started <= 1'b0;
            r_uv_idx      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CELL_WIDTH:  r_cell_width  <= i_cfg_data[7:0];
                    CFG_CELL_HEIGHT: r_cell_height <= i_cfg_data[7:0];
                    CFG_QUAD_LIMIT:  r_quad_limit  <= i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end

            if (r_state == ST_LOOKUP) begin
                r_uv_idx <= '0;
                if (r_code == NEWLINE_CODE) begin
                    r_widest <= widest_now;
                    r_pen_x  <= '0;
                    r_pen_y  <= r_pen_y + line_pitch;
                end else if (!visible) begin
                    r_pen_x <= r_pen_x + {{16{glyph.adv_x[15]}}, glyph.adv_x};
                    r_pen_y <= r_pen_y + {{16{glyph.adv_y[15]}}, glyph.adv_y};
                end
            end

            if (div_start) begin
                r_div_started <= 1'b1;
            end else if (div_rsp.done) begin
                r_div_started <= 1'b0;
                r_uv_idx      <= r_uv_idx + 1'b1;
            end

            if (load_quad) begin
                r_quad_count <= r_quad_count + 1'b1;
                r_pen_x      <= r_pen_x + adv_x_ext;
                r_pen_y      <= r_pen_y + adv_y_ext;
            end

            if (load_box) begin
                r_quad_count <= '0;
                r_pen_x      <= '0;
                r_pen_y      <= '0;
                r_widest     <= '0;
            end

            if (load_quad || load_box) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_code <= i_char_code;
        end
        if (r_state == ST_LOOKUP) begin
            r_glyph <= glyph;
            r_xl    <= r_pen_x + {{18{glyph.left[7]}}, glyph.left, 6'd0};
            r_yu    <= r_pen_y - {{18{glyph.top[7]}}, glyph.top, 6'd0};
            r_mx    <= OFFS_W'(r_cell_width) * OFFS_W'(r_code[3:0]);
            r_my    <= OFFS_W'(r_cell_height) * OFFS_W'(r_code[7:4]);
        end
        if (div_rsp.done) begin
            r_uv[r_uv_idx] <= div_rsp.coord;
        end
        if (load_quad) begin
            r_out_kind  <= 1'b0;
            r_out_count <= r_quad_count + 1'b1;
            r_out_xl    <= r_xl;
            r_out_yu    <= r_yu;
            r_out_xr    <= r_xl + {18'd0, r_glyph.w, 6'd0};
            r_out_yl    <= r_yu + {18'd0, r_glyph.h, 6'd0};
            r_out_ul    <= r_uv[0];
            r_out_vu    <= r_uv[1];
            r_out_ur    <= r_uv[2];
            r_out_vl    <= r_uv[3];
            r_out_bw    <= '0;
            r_out_bh    <= '0;
        end else if (load_box) begin
            r_out_kind  <= 1'b1;
            r_out_count <= r_quad_count;
            r_out_xl    <= '0;
            r_out_yu    <= '0;
            r_out_xr    <= '0;
            r_out_yl    <= '0;
            r_out_ul    <= '0;
            r_out_vu    <= '0;
            r_out_ur    <= '0;
            r_out_vl    <= '0;
            r_out_bw    <= widest_now;
            r_out_bh    <= r_pen_y + line_pitch;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_quads_so_far = r_out_count;
    assign o_x_left       = r_out_xl;
    assign o_y_upper      = r_out_yu;
    assign o_x_right      = r_out_xr;
    assign o_y_lower      = r_out_yl;
    assign o_u_left       = r_out_ul;
    assign o_v_upper      = r_out_vu;
    assign o_u_right      = r_out_ur;
    assign o_v_lower      = r_out_vl;
    assign o_box_width    = r_out_bw;
    assign o_box_height   = r_out_bh;

endmodule
